// ===== rtl/ckm_pkg.sv =====
// shared constants and opcode type for the per-key best-track clone marker
// no dependencies; used by every module of the block
package ckm_pkg;

  // fixed port widths
  localparam int OP_W    = 2;
  localparam int IDX_W   = 6;
  localparam int KEY_W   = 8;
  localparam int LOOP_W  = 8;
  localparam int HITIN_W = 12;

  // parameter defaults
  localparam int DEF_MAX_TRACKS     = 64;
  localparam int DEF_MAX_KEYS       = 256;
  localparam int DEF_HIT_COUNT_BITS = 12;

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

endpackage

// ===== rtl/ckm_key_table.sv =====
// per-key best entry memory with the best-track contest compare
// depends on ckm_pkg
module ckm_key_table #(
  parameter int MAX_KEYS       = ckm_pkg::DEF_MAX_KEYS,
  parameter int HIT_COUNT_BITS = ckm_pkg::DEF_HIT_COUNT_BITS,
  parameter int TRACK_AW       = $clog2(ckm_pkg::DEF_MAX_TRACKS),
  parameter int KEY_AW         = $clog2(ckm_pkg::DEF_MAX_KEYS)
) (
  input  logic                         clk,
  input  logic [KEY_AW-1:0]            raddr,
  output logic                         rd_has_best,
  output logic [TRACK_AW-1:0]          rd_best_track,
  input  logic [ckm_pkg::LOOP_W-1:0]   cand_loops,
  input  logic [HIT_COUNT_BITS-1:0]    cand_hits,
  output logic                         better,
  input  logic                         wr_en,
  input  logic [KEY_AW-1:0]            waddr,
  input  logic                         wr_has_best,
  input  logic [ckm_pkg::LOOP_W-1:0]   wr_loops,
  input  logic [HIT_COUNT_BITS-1:0]    wr_hits,
  input  logic [TRACK_AW-1:0]          wr_track
);
  import ckm_pkg::*;

  localparam int EW = 1 + LOOP_W + HIT_COUNT_BITS + TRACK_AW;

  logic [EW-1:0]             mem [MAX_KEYS];
  logic [EW-1:0]             rdata;
  logic [LOOP_W-1:0]         rd_loops;
  logic [HIT_COUNT_BITS-1:0] rd_hits;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= {wr_has_best, wr_loops, wr_hits, wr_track};
    end
    rdata <= mem[raddr];
  end

  assign {rd_has_best, rd_loops, rd_hits, rd_best_track} = rdata;

  // smaller loop count wins, then more correct hits; full tie keeps the old best
  always_comb begin
    if (!rd_has_best) begin
      better = 1'b1;
    end else if (cand_loops != rd_loops) begin
      better = cand_loops < rd_loops;
    end else begin
      better = cand_hits > rd_hits;
    end
  end

endmodule

// ===== rtl/ckm_track_table.sv =====
// per-track record memory: known flag, matched flag and truth key
// depends on ckm_pkg
module ckm_track_table #(
  parameter int MAX_TRACKS = ckm_pkg::DEF_MAX_TRACKS,
  parameter int TRACK_AW   = $clog2(ckm_pkg::DEF_MAX_TRACKS),
  parameter int KEY_AW     = $clog2(ckm_pkg::DEF_MAX_KEYS)
) (
  input  logic                clk,
  input  logic [TRACK_AW-1:0] raddr,
  output logic                rd_known,
  output logic                rd_matched,
  output logic [KEY_AW-1:0]   rd_key,
  input  logic                wr_en,
  input  logic [TRACK_AW-1:0] waddr,
  input  logic                wr_known,
  input  logic                wr_matched,
  input  logic [KEY_AW-1:0]   wr_key
);
  import ckm_pkg::*;

  localparam int EW = 2 + KEY_AW;

  logic [EW-1:0] mem [MAX_TRACKS];
  logic [EW-1:0] rdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= {wr_known, wr_matched, wr_key};
    end
    rdata <= mem[raddr];
  end

  assign {rd_known, rd_matched, rd_key} = rdata;

endmodule

// ===== rtl/per_key_best_track_clone_marker_core.sv =====
// top level of the per-key best-track clone marker: sequencer over two tables
// depends on ckm_pkg, ckm_key_table, ckm_track_table
//
//  channel  | signals                                             | handshake
//  ---------+-----------------------------------------------------+------------------------
//  command  | opcode track_index matched truth_key first_loops    | start & !busy
//           | correct_hits                                        |
//  result   | is_clone unknown_track                              | done, one cycle, no stall
//
// steps: an add reads the key table at accept, then compares and writes back;
//   a query reads the track table, then issues a dependent key table read; an
//   unused opcode answers from idle with no table access
// a clear sweeps both tables over max(MAX_TRACKS, MAX_KEYS) entries, one entry a cycle,
//   set by the single write port of each table
// reset starts the same sweep, so busy stays high after rst falls until the
//   sweep ends; no result word comes from it
// done pulses for one cycle with the result word; the receiver cannot stall it
module per_key_best_track_clone_marker_core #(
  parameter int MAX_TRACKS     = ckm_pkg::DEF_MAX_TRACKS,
  parameter int MAX_KEYS       = ckm_pkg::DEF_MAX_KEYS,
  parameter int HIT_COUNT_BITS = ckm_pkg::DEF_HIT_COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [ckm_pkg::OP_W-1:0]      opcode,
  input  logic [ckm_pkg::IDX_W-1:0]     track_index,
  input  logic                          matched,
  input  logic [ckm_pkg::KEY_W-1:0]     truth_key,
  input  logic [ckm_pkg::LOOP_W-1:0]    first_loops,
  input  logic [ckm_pkg::HITIN_W-1:0]   correct_hits,
  output logic                          done,
  output logic                          is_clone,
  output logic                          unknown_track
);
  import ckm_pkg::*;

  localparam int TRACK_AW  = $clog2(MAX_TRACKS);
  localparam int KEY_AW    = $clog2(MAX_KEYS);
  localparam int CLR_DEPTH = (MAX_TRACKS > MAX_KEYS) ? MAX_TRACKS : MAX_KEYS;
  localparam int CNT_W     = $clog2(CLR_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_QTRK,
    S_QKEY,
    S_CLR
  } state_t;

  state_t state;

  // captured command word
  logic                      idx_ok;
  logic                      key_ok;
  logic [TRACK_AW-1:0]       idx;
  logic                      mflag;
  logic [KEY_AW-1:0]         key;
  logic [LOOP_W-1:0]         loops;
  logic [HIT_COUNT_BITS-1:0] hits;

  // clear sweep
  logic [CNT_W-1:0] cnt;
  logic             clr_reply;

  // table ports
  logic [KEY_AW-1:0]         key_raddr;
  logic                      key_has_best;
  logic [TRACK_AW-1:0]       key_best_track;
  logic                      key_better;
  logic                      key_we;
  logic [KEY_AW-1:0]         key_waddr;
  logic                      key_wr_has_best;
  logic [TRACK_AW-1:0]       trk_raddr;
  logic                      trk_known;
  logic                      trk_matched;
  logic [KEY_AW-1:0]         trk_key;
  logic                      trk_we;
  logic [TRACK_AW-1:0]       trk_waddr;
  logic                      trk_wr_known;
  logic                      trk_wr_matched;
  logic [KEY_AW-1:0]         trk_wr_key;

  logic accept;
  logic add_ok;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // an add is dropped for an index out of range or a matched add with a key out of range
  assign add_ok = idx_ok && (!mflag || key_ok);

  // read addresses: straight from the command at accept, else the held index and the key read from the track table
  assign trk_raddr = (state == S_IDLE) ? TRACK_AW'(track_index) : idx;
  assign key_raddr = (state == S_IDLE) ? KEY_AW'(truth_key) : trk_key;

  // write side: clear sweep, or the add write back
  always_comb begin
    if (state == S_CLR) begin
      trk_we          = 1'b1;
      trk_waddr       = TRACK_AW'(cnt);
      trk_wr_known    = 1'b0;
      trk_wr_matched  = 1'b0;
      trk_wr_key      = '0;
      key_we          = 1'b1;
      key_waddr       = KEY_AW'(cnt);
      key_wr_has_best = 1'b0;
    end else begin
      trk_we          = (state == S_ADD) && add_ok;
      trk_waddr       = idx;
      trk_wr_known    = 1'b1;
      trk_wr_matched  = mflag;
      trk_wr_key      = mflag ? key : '0;
      key_we          = (state == S_ADD) && add_ok && mflag && key_better;
      key_waddr       = key;
      key_wr_has_best = 1'b1;
    end
  end

  ckm_key_table #(
    .MAX_KEYS       (MAX_KEYS),
    .HIT_COUNT_BITS (HIT_COUNT_BITS),
    .TRACK_AW       (TRACK_AW),
    .KEY_AW         (KEY_AW)
  ) u_key_table (
    .clk           (clk),
    .raddr         (key_raddr),
    .rd_has_best   (key_has_best),
    .rd_best_track (key_best_track),
    .cand_loops    (loops),
    .cand_hits     (hits),
    .better        (key_better),
    .wr_en         (key_we),
    .waddr         (key_waddr),
    .wr_has_best   (key_wr_has_best),
    .wr_loops      (loops),
    .wr_hits       (hits),
    .wr_track      (idx)
  );

  ckm_track_table #(
    .MAX_TRACKS (MAX_TRACKS),
    .TRACK_AW   (TRACK_AW),
    .KEY_AW     (KEY_AW)
  ) u_track_table (
    .clk        (clk),
    .raddr      (trk_raddr),
    .rd_known   (trk_known),
    .rd_matched (trk_matched),
    .rd_key     (trk_key),
    .wr_en      (trk_we),
    .waddr      (trk_waddr),
    .wr_known   (trk_wr_known),
    .wr_matched (trk_wr_matched),
    .wr_key     (trk_wr_key)
  );

  // sequencer with registered result word
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      cnt           <= '0;
      clr_reply     <= 1'b0;
      done          <= 1'b0;
      is_clone      <= 1'b0;
      unknown_track <= 1'b0;
    end else begin
      done          <= 1'b0;
      is_clone      <= 1'b0;
      unknown_track <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            idx_ok <= int'(track_index) < MAX_TRACKS;
            key_ok <= int'(truth_key) < MAX_KEYS;
            idx    <= TRACK_AW'(track_index);
            mflag  <= matched;
            key    <= KEY_AW'(truth_key);
            loops  <= first_loops;
            hits   <= HIT_COUNT_BITS'(correct_hits);
            case (opcode)
              OP_ADD: begin
                state <= S_ADD;
              end
              OP_QUERY: begin
                state <= S_QTRK;
              end
              OP_CLEAR: begin
                state     <= S_CLR;
                cnt       <= '0;
                clr_reply <= 1'b1;
              end
              default: begin
                // unused opcode: empty result word right away
                done <= 1'b1;
              end
            endcase
          end
        end
        S_ADD: begin
          // table writes happen this cycle
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_QTRK: begin
          // track record is out; key read issued from its stored key
          state <= S_QKEY;
        end
        S_QKEY: begin
          done          <= 1'b1;
          unknown_track <= !idx_ok || !trk_known;
          is_clone      <= idx_ok && trk_known && trk_matched && key_has_best
                           && (key_best_track != idx);
          state         <= S_IDLE;
        end
        S_CLR: begin
          if (cnt == CNT_W'(CLR_DEPTH - 1)) begin
            done      <= clr_reply;
            clr_reply <= 1'b0;
            state     <= S_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== tb/sv/clone_verdict_checker.sv =====
// checker for the per-key best-track clone marker: predicts each result word and compares it
// depends on ckm_pkg for widths, table sizes and opcodes
module clone_verdict_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [ckm_pkg::OP_W-1:0]    opcode,
  input  logic [ckm_pkg::IDX_W-1:0]   track_index,
  input  logic                        matched,
  input  logic [ckm_pkg::KEY_W-1:0]   truth_key,
  input  logic [ckm_pkg::LOOP_W-1:0]  first_loops,
  input  logic [ckm_pkg::HITIN_W-1:0] correct_hits,
  input  logic                        done,
  input  logic                        is_clone,
  input  logic                        unknown_track,
  output int                          errors,
  output int                          outstanding
);

  localparam int NKEYS   = ckm_pkg::DEF_MAX_KEYS;
  localparam int NTRACKS = ckm_pkg::DEF_MAX_TRACKS;

  typedef struct packed {
    logic clone;
    logic unknown;
  } verdict_t;

  // per-key best entry
  logic                        key_valid [NKEYS];
  logic [ckm_pkg::LOOP_W-1:0]  key_loops [NKEYS];
  logic [ckm_pkg::HITIN_W-1:0] key_hits  [NKEYS];
  logic [ckm_pkg::IDX_W-1:0]   key_owner [NKEYS];
  // per-track record
  logic                        trk_valid   [NTRACKS];
  logic                        trk_matched [NTRACKS];
  logic [ckm_pkg::KEY_W-1:0]   trk_key     [NTRACKS];

  verdict_t verdict_q [$];
  int mismatches = 0;
  int waiting = 0;

  assign errors = mismatches;
  assign outstanding = waiting;

  task automatic wipe_tables();
    for (int k = 0; k < NKEYS; k++) key_valid[k] = 1'b0;
    for (int t = 0; t < NTRACKS; t++) trk_valid[t] = 1'b0;
  endtask

  task automatic predict_verdict(
    input  logic [ckm_pkg::OP_W-1:0]    op,
    input  logic [ckm_pkg::IDX_W-1:0]   idx,
    input  logic                        m,
    input  logic [ckm_pkg::KEY_W-1:0]   key,
    input  logic [ckm_pkg::LOOP_W-1:0]  loops,
    input  logic [ckm_pkg::HITIN_W-1:0] hits,
    output verdict_t                    v
  );
    logic better;
    logic [ckm_pkg::KEY_W-1:0] k;
    v = '0;
    case (op)
      ckm_pkg::OP_ADD: begin
        trk_valid[idx]   = 1'b1;
        trk_matched[idx] = m;
        trk_key[idx]     = m ? key : '0;
        if (m) begin
          if (!key_valid[key]) better = 1'b1;
          else if (loops != key_loops[key]) better = loops < key_loops[key];
          else better = hits > key_hits[key];
          if (better) begin
            key_valid[key] = 1'b1;
            key_loops[key] = loops;
            key_hits[key]  = hits;
            key_owner[key] = idx;
          end
        end
      end
      ckm_pkg::OP_QUERY: begin
        if (!trk_valid[idx]) begin
          v.unknown = 1'b1;
        end else if (trk_matched[idx]) begin
          k = trk_key[idx];
          if (key_valid[k] && key_owner[k] != idx) v.clone = 1'b1;
        end
      end
      ckm_pkg::OP_CLEAR: wipe_tables();
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    verdict_t want;
    if (rst) begin
      wipe_tables();
      verdict_q.delete();
    end else begin
      if (start === 1'b1 && busy === 1'b0) begin
        predict_verdict(opcode, track_index, matched, truth_key, first_loops, correct_hits,
                        want);
        verdict_q.insert(verdict_q.size(), want);
      end
      if (done === 1'b1) begin
        if (verdict_q.size() == 0) begin
          $error("result word with no command waiting");
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          if (is_clone !== want.clone) begin
            $error("is_clone mismatch: expected %0b actual %0b", want.clone, is_clone);
            mismatches++;
          end
          if (unknown_track !== want.unknown) begin
            $error("unknown_track mismatch: expected %0b actual %0b", want.unknown,
                   unknown_track);
            mismatches++;
          end
        end
      end
    end
    waiting <= verdict_q.size();
  end

endmodule

// ===== tb/sv/per_key_best_track_clone_marker_core_test.sv =====
// testbench top for the per-key best-track clone marker: drives command words, gives the verdict
// depends on ckm_pkg, per_key_best_track_clone_marker_core and clone_verdict_checker
module per_key_best_track_clone_marker_core_test;

  // longest legal quiet stretch is a clear sweep plus the longest random gap of send_word
  localparam int IDLE_LIMIT = 2000;
  localparam int N_RANDOM   = 1150;
  // the one opcode with no meaning; the block must answer it with a zero word
  localparam logic [ckm_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  logic                        clk;
  logic                        rst;
  logic                        start;
  logic                        busy;
  logic [ckm_pkg::OP_W-1:0]    opcode;
  logic [ckm_pkg::IDX_W-1:0]   track_index;
  logic                        matched;
  logic [ckm_pkg::KEY_W-1:0]   truth_key;
  logic [ckm_pkg::LOOP_W-1:0]  first_loops;
  logic [ckm_pkg::HITIN_W-1:0] correct_hits;
  logic                        done;
  logic                        is_clone;
  logic                        unknown_track;

  int errors;
  int pending;
  int idle_cycles = 0;
  // words left in the current run of back-to-back commands
  int calm_left = 0;

  per_key_best_track_clone_marker_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .track_index  (track_index),
    .matched      (matched),
    .truth_key    (truth_key),
    .first_loops  (first_loops),
    .correct_hits (correct_hits),
    .done         (done),
    .is_clone     (is_clone),
    .unknown_track(unknown_track)
  );

  clone_verdict_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .track_index  (track_index),
    .matched      (matched),
    .truth_key    (truth_key),
    .first_loops  (first_loops),
    .correct_hits (correct_hits),
    .done         (done),
    .is_clone     (is_clone),
    .unknown_track(unknown_track),
    .errors       (errors),
    .outstanding  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog: any accepted command or result word restarts the count
  always @(posedge clk) begin
    if (rst === 1'b1 || (start === 1'b1 && busy === 1'b0) || done === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one command word: optional random gap with start low, then hold start
  // until the block takes the word; called and returns at a falling edge
  task automatic send_word(
    input logic [ckm_pkg::OP_W-1:0]    op,
    input logic [ckm_pkg::IDX_W-1:0]   idx,
    input logic                        m,
    input logic [ckm_pkg::KEY_W-1:0]   key,
    input logic [ckm_pkg::LOOP_W-1:0]  loops,
    input logic [ckm_pkg::HITIN_W-1:0] hits
  );
    int gap;
    if (calm_left > 0) begin
      gap = 0;
      calm_left--;
    end else begin
      gap = $urandom_range(0, 14);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start        <= 1'b1;
    opcode       <= op;
    track_index  <= idx;
    matched      <= m;
    truth_key    <= key;
    first_loops  <= loops;
    correct_hits <= hits;
    // accept happens at the first rising edge that sees busy low
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(negedge clk);
  endtask

  // hold the sender off until every predicted word has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    logic [ckm_pkg::IDX_W-1:0]   idx;
    logic                        m;
    logic [ckm_pkg::KEY_W-1:0]   key;
    logic [ckm_pkg::KEY_W-1:0]   key_base;
    logic [ckm_pkg::LOOP_W-1:0]  loops;
    logic [ckm_pkg::HITIN_W-1:0] hits;
    logic [ckm_pkg::IDX_W-1:0]   added [$];
    int pick;

    rst          = 1'b1;
    start        = 1'b0;
    opcode       = ckm_pkg::OP_ADD;
    track_index  = '0;
    matched      = 1'b0;
    truth_key    = '0;
    first_loops  = '0;
    correct_hits = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    // the reset sweep keeps busy high for a while; send_word simply waits it out

    // directed: empty tables, both ends of the index range
    send_word(ckm_pkg::OP_QUERY, 6'd0,  1'b0, 8'd0,   8'd0,   12'd0);
    send_word(ckm_pkg::OP_QUERY, 6'd63, 1'b1, 8'd255, 8'd255, 12'hfff);
    // first entry of key 0, then a full tie: the earlier track must stay best
    send_word(ckm_pkg::OP_ADD,   6'd0,  1'b1, 8'd0,   8'd255, 12'd0);
    send_word(ckm_pkg::OP_ADD,   6'd63, 1'b1, 8'd0,   8'd255, 12'd0);
    send_word(ckm_pkg::OP_QUERY, 6'd63, 1'b0, 8'd0,   8'd0,   12'd0);
    send_word(ckm_pkg::OP_QUERY, 6'd0,  1'b0, 8'd0,   8'd0,   12'd0);
    // same loops, more hits takes over
    send_word(ckm_pkg::OP_ADD,   6'd1,  1'b1, 8'd0,   8'd255, 12'hfff);
    send_word(ckm_pkg::OP_QUERY, 6'd0,  1'b0, 8'd0,   8'd0,   12'd0);
    send_word(ckm_pkg::OP_QUERY, 6'd1,  1'b0, 8'd0,   8'd0,   12'd0);
    // fewer loops beats any hit count
    send_word(ckm_pkg::OP_ADD,   6'd2,  1'b1, 8'd0,   8'd0,   12'd0);
    send_word(ckm_pkg::OP_QUERY, 6'd1,  1'b0, 8'd0,   8'd0,   12'd0);
    send_word(ckm_pkg::OP_QUERY, 6'd2,  1'b0, 8'd0,   8'd0,   12'd0);
    // unmatched track is never a clone; top key value
    send_word(ckm_pkg::OP_ADD,   6'd3,  1'b0, 8'd255, 8'd7,   12'd9);
    send_word(ckm_pkg::OP_QUERY, 6'd3,  1'b0, 8'd0,   8'd0,   12'd0);
    send_word(ckm_pkg::OP_ADD,   6'd4,  1'b1, 8'd255, 8'd0,   12'hfff);
    send_word(ckm_pkg::OP_QUERY, 6'd4,  1'b0, 8'd0,   8'd0,   12'd0);
    // re-add of the current best as unmatched: key 0 still names track 2
    send_word(ckm_pkg::OP_ADD,   6'd2,  1'b0, 8'd0,   8'd0,   12'd0);
    send_word(ckm_pkg::OP_QUERY, 6'd2,  1'b0, 8'd0,   8'd0,   12'd0);
    send_word(ckm_pkg::OP_QUERY, 6'd1,  1'b0, 8'd0,   8'd0,   12'd0);
    // re-add of track 1 wins the contest again on hits
    send_word(ckm_pkg::OP_ADD,   6'd1,  1'b1, 8'd0,   8'd0,   12'hfff);
    send_word(ckm_pkg::OP_QUERY, 6'd1,  1'b0, 8'd0,   8'd0,   12'd0);
    // unused opcode, then clear, then the tables must look empty
    send_word(OP_UNUSED,         6'd1,  1'b1, 8'd0,   8'd0,   12'd0);
    send_word(ckm_pkg::OP_CLEAR, 6'd63, 1'b1, 8'd255, 8'd255, 12'hfff);
    send_word(ckm_pkg::OP_QUERY, 6'd0,  1'b0, 8'd0,   8'd0,   12'd0);
    send_word(ckm_pkg::OP_ADD,   6'd5,  1'b1, 8'd0,   8'd200, 12'd1);
    send_word(ckm_pkg::OP_QUERY, 6'd5,  1'b0, 8'd0,   8'd0,   12'd0);

    // sender pause while the block drains
    wait_drained();

    // random phase: adds crowd a few keys so contests and ties are common,
    // queries mostly hit tracks added since the last clear
    key_base = 8'($urandom);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 2) wait_drained();
      if (calm_left == 0 && $urandom_range(0, 39) == 0) calm_left = 25;
      pick  = $urandom_range(0, 99);
      idx   = 6'($urandom);
      m     = 1'($urandom);
      key   = 8'($urandom);
      loops = 8'($urandom);
      hits  = 12'($urandom);
      if (pick < 46) begin
        m = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 3) != 0) key = key_base + 8'($urandom_range(0, 3));
        if ($urandom_range(0, 2) != 0) loops = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 2) != 0) hits = 12'($urandom_range(0, 3));
        added.insert(added.size(), idx);
        send_word(ckm_pkg::OP_ADD, idx, m, key, loops, hits);
      end else if (pick < 96) begin
        if (added.size() != 0 && $urandom_range(0, 3) != 0)
          idx = added[$urandom_range(0, added.size() - 1)];
        send_word(ckm_pkg::OP_QUERY, idx, m, key, loops, hits);
      end else if (pick < 98) begin
        added.delete();
        key_base = 8'($urandom);
        send_word(ckm_pkg::OP_CLEAR, idx, m, key, loops, hits);
      end else begin
        send_word(OP_UNUSED, idx, m, key, loops, hits);
      end
    end

    // drain, then watch a little longer for stray result words
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
